// File: rtl/lov_pkg.sv
package lov_pkg;

    // Fixed field widths.
    localparam int MODE_W  = 2;
    localparam int ALPHA_W = 8;
    localparam int MAX_W   = 16;
    localparam int CHAN_W  = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    // Divider remainder width: a dividend below max * 256 fits here.
    localparam int REM_W   = MAX_W + CHAN_W;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_OPACITY = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX     = 2'd2;

    // Reset values of the registers.
    localparam logic [ALPHA_W-1:0] OPACITY_RST = 8'd64;
    localparam logic [MAX_W-1:0]   MAX_RST     = 16'd1;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE  = 2'd0,
        MODE_TRANS = 2'd1,
        MODE_SOLID = 2'd2,
        MODE_MULTI = 2'd3
    } mode_t;

    // How the quotient is placed into the output pixel.
    typedef enum logic [2:0] {
        KIND_ZERO  = 3'd0,
        KIND_TRANS = 3'd1,
        KIND_SOLID = 3'd2,
        KIND_JET0  = 3'd3,
        KIND_JET1  = 3'd4,
        KIND_JET2  = 3'd5,
        KIND_JET3  = 3'd6
    } kind_t;

endpackage

// File: rtl/label_overlay_colorizer.sv
// Pipeline: a result passes through registered stages for select and multiply,
// then four stages of a restoring divider that resolves two quotient bits each.
// Throughput: one item per cycle; the whole pipeline holds while the output stalls.
// Reset: asynchronous, active low; empties the pipeline and loads mode multilabel,
// opacity factor 64 and label maximum 1.
module label_overlay_colorizer #(
    parameter int LABEL_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lov_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lov_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [LABEL_BITS-1:0]       label_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lov_pkg::CHAN_W-1:0]  red,
    output logic [lov_pkg::CHAN_W-1:0]  green,
    output logic [lov_pkg::CHAN_W-1:0]  blue,
    output logic [lov_pkg::CHAN_W-1:0]  alpha
);
    import lov_pkg::*;

    // Operand width covers both the label and a colormap distance.
    localparam int AW = (LABEL_BITS > MAX_W) ? LABEL_BITS : MAX_W;
    localparam int NW = AW + CHAN_W;

    // Configuration registers.
    mode_t              mode_reg;
    logic [ALPHA_W-1:0] opacity_reg;
    logic [MAX_W-1:0]   max_reg;
    logic [MAX_W-1:0]   m_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_MULTI;
            opacity_reg <= OPACITY_RST;
            max_reg     <= MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE:    mode_reg    <= mode_t'(cfg_data[MODE_W-1:0]);
                REG_OPACITY: opacity_reg <= cfg_data[ALPHA_W-1:0];
                REG_MAX:     max_reg     <= cfg_data[MAX_W-1:0];
                default:     ;
            endcase
        end
    end

    // A zero maximum behaves as one.
    assign m_eff = (max_reg == '0) ? MAX_W'(1) : max_reg;

    // One restoring step: subtract the divisor shifted by k when it fits.
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic [MAX_W-1:0] dvs,
                                                input int k);
        logic [REM_W-1:0] sh;
        begin
            sh = REM_W'(dvs) << k;
            if (rem >= sh)
                div_step = {1'b1, rem - sh};
            else
                div_step = {1'b0, rem};
        end
    endfunction

    // The pipeline moves as a whole unless a result waits at the output.
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Stage 1: pick the multiplication operands and the colormap segment.
    logic [AW-1:0]     lab_ext;
    logic [AW-1:0]     m_ext;
    logic [MAX_W-1:0]  v;
    logic [MAX_W+1:0]  v4, m1, m2, m3, m4, seg_dist;
    kind_t             s1_kind_next;
    logic [AW-1:0]     s1_a_next;
    logic [CHAN_W-1:0] s1_b_next;

    always_comb
    begin
        lab_ext = AW'(label_value);
        m_ext   = AW'(m_eff);
        v       = (lab_ext > m_ext) ? m_eff : lab_ext[MAX_W-1:0];
        v4      = {v, 2'b00};
        m1      = {2'b00, m_eff};
        m2      = {1'b0, m_eff, 1'b0};
        m3      = m1 + m2;
        m4      = {m_eff, 2'b00};
        seg_dist = '0;
        s1_kind_next = KIND_ZERO;
        s1_a_next    = '0;
        s1_b_next    = '0;
        unique case (mode_reg)
            MODE_NONE:
            begin
                s1_kind_next = KIND_ZERO;
            end
            MODE_TRANS:
            begin
                s1_kind_next = KIND_TRANS;
                s1_a_next    = lab_ext;
                s1_b_next    = opacity_reg;
            end
            MODE_SOLID:
            begin
                s1_kind_next = KIND_SOLID;
                s1_a_next    = lab_ext;
                s1_b_next    = CHAN_FULL;
            end
            MODE_MULTI:
            begin
                // Jet map: distance from a segment edge, scaled by 255 later.
                if (v4 < m1)
                begin
                    s1_kind_next = KIND_JET0;
                    seg_dist     = v4;
                end
                else if (v4 < m2)
                begin
                    s1_kind_next = KIND_JET1;
                    seg_dist     = m2 - v4;
                end
                else if (v4 < m3)
                begin
                    s1_kind_next = KIND_JET2;
                    seg_dist     = v4 - m2;
                end
                else
                begin
                    s1_kind_next = KIND_JET3;
                    seg_dist     = m4 - v4;
                end
                if (lab_ext == '0)
                    s1_kind_next = KIND_ZERO;
                s1_a_next = AW'(seg_dist[MAX_W-1:0]);
                s1_b_next = CHAN_FULL;
            end
            default: ;
        endcase
    end

    logic              s1_valid_reg;
    kind_t             s1_kind_reg;
    logic [AW-1:0]     s1_a_reg;
    logic [CHAN_W-1:0] s1_b_reg;

    // Stage 2: the dividend.
    logic          s2_valid_reg;
    kind_t         s2_kind_reg;
    logic [NW-1:0] s2_n_reg;
    logic [NW-1:0] s2_n_next;

    assign s2_n_next = NW'(s1_a_reg) * NW'(s1_b_reg);

    // Stage 3: saturation check and quotient bits 7 and 6.
    logic              sat;
    logic [REM_W:0]    st7, st6, st5, st4, st3, st2, st1, st0;
    logic [REM_W-1:0]  rem0;
    logic [CHAN_W-1:0] s3_q_next;
    logic [REM_W-1:0]  s3_rem_next;

    assign sat  = s2_n_reg >= NW'({m_eff, 8'b0});
    assign rem0 = sat ? '0 : s2_n_reg[REM_W-1:0];
    assign st7  = div_step(rem0, m_eff, 7);
    assign st6  = div_step(st7[REM_W-1:0], m_eff, 6);
    assign s3_q_next   = sat ? CHAN_FULL : {st7[REM_W], st6[REM_W], 6'b0};
    assign s3_rem_next = st6[REM_W-1:0];

    logic              s3_valid_reg;
    kind_t             s3_kind_reg;
    logic [CHAN_W-1:0] s3_q_reg;
    logic [REM_W-1:0]  s3_rem_reg;

    // Stage 4: quotient bits 5 and 4.
    assign st5 = div_step(s3_rem_reg, m_eff, 5);
    assign st4 = div_step(st5[REM_W-1:0], m_eff, 4);

    logic              s4_valid_reg;
    kind_t             s4_kind_reg;
    logic [CHAN_W-1:0] s4_q_reg;
    logic [REM_W-1:0]  s4_rem_reg;

    // Stage 5: quotient bits 3 and 2.
    assign st3 = div_step(s4_rem_reg, m_eff, 3);
    assign st2 = div_step(st3[REM_W-1:0], m_eff, 2);

    logic              s5_valid_reg;
    kind_t             s5_kind_reg;
    logic [CHAN_W-1:0] s5_q_reg;
    logic [REM_W-1:0]  s5_rem_reg;

    // Output stage: last two bits, then place the quotient into the pixel.
    logic [CHAN_W-1:0] q;
    logic [CHAN_W-1:0] red_next, green_next, blue_next, alpha_next;

    assign st1 = div_step(s5_rem_reg, m_eff, 1);
    assign st0 = div_step(st1[REM_W-1:0], m_eff, 0);
    assign q   = s5_q_reg | {6'b0, st1[REM_W], st0[REM_W]};

    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        alpha_next = opacity_reg;
        case (s5_kind_reg)
            KIND_TRANS:
            begin
                green_next = CHAN_FULL;
                blue_next  = CHAN_FULL;
                alpha_next = q;
            end
            KIND_SOLID:
            begin
                red_next   = q;
                green_next = q;
                blue_next  = q;
            end
            KIND_JET0:
            begin
                green_next = q;
                blue_next  = CHAN_FULL;
            end
            KIND_JET1:
            begin
                green_next = CHAN_FULL;
                blue_next  = q;
            end
            KIND_JET2:
            begin
                red_next   = q;
                green_next = CHAN_FULL;
            end
            KIND_JET3:
            begin
                red_next   = CHAN_FULL;
                green_next = q;
            end
            default:
            begin
                alpha_next = '0;
            end
        endcase
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            out_valid    <= s5_valid_reg;
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= s1_kind_next;
            s1_a_reg    <= s1_a_next;
            s1_b_reg    <= s1_b_next;
            s2_kind_reg <= s1_kind_reg;
            s2_n_reg    <= s2_n_next;
            s3_kind_reg <= s2_kind_reg;
            s3_q_reg    <= s3_q_next;
            s3_rem_reg  <= s3_rem_next;
            s4_kind_reg <= s3_kind_reg;
            s4_q_reg    <= s3_q_reg | {2'b0, st5[REM_W], st4[REM_W], 4'b0};
            s4_rem_reg  <= st4[REM_W-1:0];
            s5_kind_reg <= s4_kind_reg;
            s5_q_reg    <= s4_q_reg | {4'b0, st3[REM_W], st2[REM_W], 2'b0};
            s5_rem_reg  <= st2[REM_W-1:0];
            red         <= red_next;
            green       <= green_next;
            blue        <= blue_next;
            alpha       <= alpha_next;
        end
    end

    // Colormap distances never exceed the label maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_kind_reg == KIND_JET1 || s1_kind_reg == KIND_JET2
                         || s1_kind_reg == KIND_JET3)
        |-> s1_a_reg <= AW'(m_eff))
        else $error("colormap distance above label maximum");

    // Remainder stays below the divisor at the weight last resolved.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_rem_reg < (REM_W'(m_eff) << 6))
        else $error("divider remainder out of range after stage 3");

    assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> s4_rem_reg < (REM_W'(m_eff) << 4))
        else $error("divider remainder out of range after stage 4");

    assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> s5_rem_reg < (REM_W'(m_eff) << 2))
        else $error("divider remainder out of range after stage 5");

endmodule
